// ===== hw/rtl/tap_shake_gesture_detector_unit_defines.svh =====
// Assertion macros used by the gesture detector engine.
`ifndef TAP_SHAKE_GESTURE_DETECTOR_UNIT_DEFINES_SVH
`define TAP_SHAKE_GESTURE_DETECTOR_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define TSG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tsg same-cycle check failed");

// Check that a condition implies another in the next cycle.
`define TSG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tsg next-cycle check failed");

`endif

// ===== hw/rtl/tsg_pkg.sv =====
// Types, constants and threshold functions for the tap and shake gesture detector.
package tsg_pkg;

	// Timestamp arithmetic width
	localparam int TIME_BITS = 32;
	typedef logic [TIME_BITS-1:0] time_t;

	// Jerk: three 17-bit absolute differences summed
	localparam int JerkW = 19;
	typedef logic [JerkW-1:0] jerk_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_ENABLE = 2'd0,
		REG_WINDOW = 2'd1,
		REG_SENS   = 2'd2
	} reg_idx_t;

	// Result codes
	typedef enum logic [2:0] {
		GE_ARMED   = 3'd0,
		GE_EXPIRED = 3'd1,
		GE_DOUBLE  = 3'd2,
		GE_TRIPLE  = 3'd3,
		GE_SHAKE   = 3'd4
	} gest_t;

	// Request kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_ARM    = 1'b1;

	// Sensitivity codes
	localparam logic [1:0] SENS_STANDARD  = 2'd1;
	localparam logic [1:0] SENS_SENSITIVE = 2'd2;

	// Window limits
	localparam logic [12:0] WindowMin   = 13'd2000;
	localparam logic [12:0] WindowMax   = 13'd8000;
	localparam logic [12:0] WindowReset = 13'd4000;

	// Gap limits in ms
	localparam time_t TapGapMin   = time_t'(55);
	localparam time_t TapGapMax   = time_t'(330);
	localparam time_t DtapSettle  = time_t'(360);
	localparam time_t ShakeGapMin = time_t'(55);
	localparam time_t ShakeGapMax = time_t'(260);
	localparam time_t ShakeSettle = time_t'(420);

	typedef struct packed {
		logic        kind;
		time_t       now;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
	} tsg_item_t;

	typedef struct packed {
		logic        enable;
		logic [12:0] window;
		logic [1:0]  sens;
	} tsg_cfg_t;

	typedef struct packed {
		logic  valid;
		gest_t gest;
	} tsg_res_t;

	function automatic jerk_t tap_limit(input logic [1:0] sens);
		priority if (sens == SENS_SENSITIVE) return jerk_t'(6200);
		else if (sens == SENS_STANDARD) return jerk_t'(7800);
		else return jerk_t'(9600);
	endfunction

	function automatic jerk_t shake_limit(input logic [1:0] sens);
		priority if (sens == SENS_SENSITIVE) return jerk_t'(2700);
		else if (sens == SENS_STANDARD) return jerk_t'(3400);
		else return jerk_t'(4100);
	endfunction

	// Absolute difference of two signed 16-bit counts
	function automatic logic [16:0] abs_diff(input logic [15:0] a, input logic [15:0] b);
		logic signed [16:0] d;
		d = 17'(signed'(a)) - 17'(signed'(b));
		return d[16] ? 17'(-d) : 17'(d);
	endfunction

endpackage

// ===== hw/rtl/tap_shake_gesture_detector_unit.sv =====
// Top level of the tap and shake gesture detector.
//
//  channel | handshake              | payload
//  --------+------------------------+----------------------------------------
//  in      | in_valid / in_ready    | kind, time_ms, accel_x, accel_y, accel_z
//  out     | out_valid / out_ready  | gesture_event
//  cfg     | cfg_we                 | cfg_addr, cfg_wdata
//
// One request per cycle while no result is stalled; a result is written to the result register
// by the single decision pass when its request leaves the input register.
// A request that causes no result finishes when it leaves the input register.
// A stalled result holds the input register; one more request may wait there.
// Reset clears all control state at once; there is no clearing pass.
module tap_shake_gesture_detector_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [31:0] time_ms,
	input  logic [15:0] accel_x,
	input  logic [15:0] accel_y,
	input  logic [15:0] accel_z,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  gesture_event,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [12:0] cfg_wdata
);
	import tsg_pkg::*;

	tsg_cfg_t  cfg_q;
	tsg_item_t item_s1;
	logic      valid_s1;
	logic      out_valid_q;
	gest_t     evt_q;
	tsg_res_t  res;
	logic      step;

	// Advance the input register when the result register is free
	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	// Write configuration registers, clamping the window
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable <= 1'b0;
			cfg_q.window <= WindowReset;
			cfg_q.sens   <= 2'd0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ENABLE: cfg_q.enable <= cfg_wdata[0];
				REG_WINDOW: begin
					priority if (cfg_wdata < WindowMin) cfg_q.window <= WindowMin;
					else if (cfg_wdata > WindowMax) cfg_q.window <= WindowMax;
					else cfg_q.window <= cfg_wdata;
				end
				REG_SENS: cfg_q.sens <= cfg_wdata[1:0];
				default: ;
			endcase
		end
	end

	// Track input register and result register occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (step && res.valid) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Capture request and result payloads
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.kind <= kind;
			item_s1.now  <= time_t'(time_ms);
			item_s1.x    <= accel_x;
			item_s1.y    <= accel_y;
			item_s1.z    <= accel_z;
		end
		if (step && res.valid) evt_q <= res.gest;
	end

	tsg_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign out_valid     = out_valid_q;
	assign gesture_event = evt_q;

endmodule

// ===== hw/rtl/tsg_engine.sv =====
// Gesture state and per-request decision logic.
`include "tap_shake_gesture_detector_unit_defines.svh"

module tsg_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  tsg_pkg::tsg_item_t item,
	input  tsg_pkg::tsg_cfg_t  cfg,
	output tsg_pkg::tsg_res_t  res
);
	import tsg_pkg::*;

	logic        armed_q, have_q;
	time_t       armed_time_q, last_tap_q, last_shake_q;
	logic [15:0] px_q, py_q, pz_q;
	logic [1:0]  tap_q;
	logic [2:0]  shake_q;

	logic        armed_d, have_d, prior_we;
	time_t       armed_time_d, last_tap_d, last_shake_d;
	logic [1:0]  tap_d;
	logic [2:0]  shake_d;
	logic [1:0]  tap_n;
	logic [2:0]  shake_eff, shake_n;

	time_t el_arm, el_tap, el_shake;
	jerk_t jerk;

	// Elapsed times and jerk of the current request
	assign el_arm   = item.now - armed_time_q;
	assign el_tap   = item.now - last_tap_q;
	assign el_shake = item.now - last_shake_q;
	assign jerk = jerk_t'(abs_diff(item.x, px_q)) + jerk_t'(abs_diff(item.y, py_q))
		+ jerk_t'(abs_diff(item.z, pz_q));

	// Decide next state and event
	always_comb begin
		armed_d      = armed_q;
		have_d       = have_q;
		armed_time_d = armed_time_q;
		last_tap_d   = last_tap_q;
		last_shake_d = last_shake_q;
		tap_d        = tap_q;
		shake_d      = shake_q;
		prior_we     = 1'b0;
		res.valid    = 1'b0;
		res.gest     = GE_ARMED;
		tap_n        = tap_q;
		shake_n      = shake_q;
		shake_eff    = (shake_q != 3'd0 && el_shake > ShakeSettle) ? 3'd0 : shake_q;
		if (!cfg.enable) begin
			armed_d = 1'b0;
			have_d  = 1'b0;
			tap_d   = 2'd0;
			shake_d = 3'd0;
		end else if (item.kind == KIND_ARM) begin
			armed_d      = 1'b1;
			have_d       = 1'b0;
			tap_d        = 2'd0;
			shake_d      = 3'd0;
			armed_time_d = item.now;
			res.valid    = 1'b1;
			res.gest     = GE_ARMED;
		end else if (!armed_q) begin
			// ignore samples while disarmed
		end else if (el_arm > time_t'(cfg.window)) begin
			armed_d   = 1'b0;
			have_d    = 1'b0;
			tap_d     = 2'd0;
			shake_d   = 3'd0;
			res.valid = 1'b1;
			res.gest  = GE_EXPIRED;
		end else if (!have_q) begin
			prior_we = 1'b1;
			have_d   = 1'b1;
		end else begin
			prior_we = 1'b1;
			if (tap_q == 2'd2 && el_tap > DtapSettle) begin
				tap_d     = 2'd0;
				armed_d   = 1'b0;
				have_d    = 1'b0;
				res.valid = 1'b1;
				res.gest  = GE_DOUBLE;
			end else if (jerk >= tap_limit(cfg.sens)) begin
				// count a tap
				if (tap_q == 2'd0 || el_tap > TapGapMax) tap_n = 2'd1;
				else if (el_tap >= TapGapMin) tap_n = tap_q + 2'd1;
				last_tap_d = item.now;
				shake_d    = 3'd0;
				if (tap_n == 2'd3) begin
					tap_d     = 2'd0;
					armed_d   = 1'b0;
					have_d    = 1'b0;
					res.valid = 1'b1;
					res.gest  = GE_TRIPLE;
				end else begin
					tap_d = tap_n;
				end
			end else if (jerk >= shake_limit(cfg.sens)) begin
				// count a shake
				shake_n = shake_eff;
				if (shake_eff == 3'd0 || el_shake > ShakeGapMax) shake_n = 3'd1;
				else if (el_shake >= ShakeGapMin) shake_n = shake_eff + 3'd1;
				last_shake_d = item.now;
				tap_d        = 2'd0;
				if (shake_n >= 3'd4) begin
					shake_d   = 3'd0;
					armed_d   = 1'b0;
					have_d    = 1'b0;
					res.valid = 1'b1;
					res.gest  = GE_SHAKE;
				end else begin
					shake_d = shake_n;
				end
			end else begin
				shake_d = shake_eff;
			end
		end
	end

	// Update control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			have_q       <= 1'b0;
			tap_q        <= 2'd0;
			shake_q      <= 3'd0;
			armed_time_q <= '0;
			last_tap_q   <= '0;
			last_shake_q <= '0;
		end else if (step) begin
			armed_q      <= armed_d;
			have_q       <= have_d;
			tap_q        <= tap_d;
			shake_q      <= shake_d;
			armed_time_q <= armed_time_d;
			last_tap_q   <= last_tap_d;
			last_shake_q <= last_shake_d;
		end
	end

	// Hold the prior sample
	always_ff @(posedge clk) begin
		if (step && prior_we) begin
			px_q <= item.x;
			py_q <= item.y;
			pz_q <= item.z;
		end
	end

	`TSG_ASSERT_NOW(a_tap_range, 1'b1, tap_q != 2'd3)
	`TSG_ASSERT_NOW(a_shake_range, 1'b1, shake_q < 3'd4)
	`TSG_ASSERT_NEXT(a_event_disarms, step && res.valid && res.gest != GE_ARMED, !armed_q)
	`TSG_ASSERT_NEXT(a_disable_clears, step && !cfg.enable, !armed_q && tap_q == 2'd0)

endmodule
